>>> sv/trm_pkg.sv
// Shared widths, register indexes and controller/datapath interface types for the rate meter.
`timescale 1ns / 1ps

package trm_pkg;

  // Field widths.
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 32;
  localparam int BPS_W   = 5;
  localparam int WIN_W   = 16;

  // Divider geometry: the dividend holds a 32-bit count times 1000.
  localparam int DIV_W   = 42;
  localparam int DVS_W   = 32;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  // Milliseconds per second.
  localparam int RATE_SCALE = 1000;

  // Register file.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_BITS_PER_SYM = 2'd0;
  localparam logic [1:0] REG_WINDOW_MS    = 2'd1;
  localparam logic [1:0] REG_AVG_MODE     = 2'd2;

  // Reset values of the registers.
  localparam logic [BPS_W-1:0] BPS_RESET = 5'd2;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;    // capture the accepted request
    logic eval;       // span check, window restart or count accumulation
    logic prod;       // count times 1000
    logic div_start;  // launch the shared divider
    logic div_mean;   // divider operands: history sum and fill (else product and span)
    logic take_rate;  // capture the saturated rate from the divider
    logic push;       // write the rate into the history
    logic sweep;      // one step of the history summing pass
    logic take_mean;  // capture the mean from the divider
    logic scale;      // speed := mean times bits per symbol, saturated
    logic raw;        // speed := rate
    logic emit;       // load the output register
    logic upd;        // the emitted result closed a window
  } trm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_neg;
    logic win_hit;
    logic div_done;
    logic sweep_done;
    logic out_free;
  } trm_sts_t;

endpackage

>>> sv/trm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module trm_div
  import trm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DCNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> sv/trm_dp.sv
// Datapath: window state, history memory, summing pass, shared divider, scaling, output register.
`timescale 1ns / 1ps

module trm_dp
  import trm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
)(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trm_cmd_t           cmd_i,
  output trm_sts_t           sts_o,
  input  logic [BPS_W-1:0]   bps_i,
  input  logic [WIN_W-1:0]   window_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [TIME_W-1:0]  now_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [SPEED_W-1:0] out_speed_o,
  output logic               out_upd_o
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = SPEED_W + FILL_W;
  localparam int SCL_W = SPEED_W + BPS_W;

  // Request capture.
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  now_q;

  // Measurement state.
  logic [TIME_W-1:0]  wstart_q;
  logic [SPEED_W-1:0] total_q;
  logic [SPEED_W-1:0] speed_q;
  logic [FILL_W-1:0]  fill_q;
  logic [HADDR_W-1:0] wptr_q;

  // Working registers.
  logic [DIV_W-1:0]   prod_q;
  logic [SPEED_W-1:0] rate_q;
  logic [SPEED_W-1:0] mean_q;
  logic [SUM_W-1:0]   acc_q;
  logic [FILL_W-1:0]  idx_q;
  logic               pend_q;
  logic [SPEED_W-1:0] rd_data_q;

  // Output register.
  logic               out_valid_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic               out_upd_q;

  logic [SPEED_W-1:0] hist_mem [HISTORY_DEPTH];

  logic [TIME_W-1:0]  span;
  logic [WIN_W-1:0]   win;
  logic [SPEED_W:0]   tot_sum;
  logic [SPEED_W-1:0] tot_sat;
  logic [DIV_W-1:0]   quot;
  logic [SPEED_W-1:0] rate_sat;
  logic [SCL_W-1:0]   scaled;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic               idx_live;

  assign span    = now_q - wstart_q;
  // A zero window behaves as one millisecond so the span divisor is never zero.
  assign win     = (window_i == '0) ? WIN_W'(1) : window_i;
  assign tot_sum = {1'b0, total_q} + (SPEED_W + 1)'(count_q);
  assign tot_sat = tot_sum[SPEED_W] ? '1 : tot_sum[SPEED_W-1:0];
  assign rate_sat = (|quot[DIV_W-1:SPEED_W]) ? '1 : quot[SPEED_W-1:0];
  assign scaled  = SCL_W'(mean_q) * SCL_W'(bps_i);
  assign idx_live = idx_q < fill_q;

  assign div_dividend = cmd_i.div_mean ? DIV_W'(acc_q) : prod_q;
  assign div_divisor  = cmd_i.div_mean ? DVS_W'(fill_q) : DVS_W'(span);

  trm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // State that the reset defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wstart_q    <= '0;
      total_q     <= '0;
      speed_q     <= '0;
      fill_q      <= '0;
      wptr_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        if (span[TIME_W-1]) begin
          wstart_q <= now_q;
        end else begin
          total_q <= tot_sat;
        end
      end
      if (cmd_i.push) begin
        wptr_q <= (wptr_q == HADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
        if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        pend_q <= 1'b0;
      end else if (cmd_i.sweep) begin
        pend_q <= idx_live;
      end
      if (cmd_i.scale) begin
        speed_q <= (|scaled[SCL_W-1:SPEED_W]) ? '1 : scaled[SPEED_W-1:0];
      end else if (cmd_i.raw) begin
        speed_q <= rate_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (cmd_i.upd) begin
          total_q  <= '0;
          wstart_q <= now_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      count_q <= count_i;
      now_q   <= now_i;
    end
    if (cmd_i.prod) begin
      prod_q <= DIV_W'(total_q) * DIV_W'(RATE_SCALE);
    end
    if (cmd_i.take_rate) begin
      rate_q <= rate_sat;
    end
    if (cmd_i.take_mean) begin
      mean_q <= quot[SPEED_W-1:0];
    end
    if (cmd_i.push) begin
      acc_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.sweep) begin
      if (idx_live) begin
        idx_q <= idx_q + 1'b1;
      end
      if (pend_q) begin
        acc_q <= acc_q + SUM_W'(rd_data_q);
      end
    end
    if (cmd_i.emit) begin
      out_speed_q <= speed_q;
      out_upd_q   <= cmd_i.upd;
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_mem[wptr_q] <= rate_q;
    end
    rd_data_q <= hist_mem[idx_q[HADDR_W-1:0]];
  end

  assign sts_o.span_neg   = span[TIME_W-1];
  assign sts_o.win_hit    = span >= TIME_W'(win);
  assign sts_o.div_done   = div_done;
  assign sts_o.sweep_done = (idx_q == fill_q) && !pend_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_speed_o = out_speed_q;
  assign out_upd_o   = out_upd_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

  a_wptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wptr_q) < HISTORY_DEPTH)
    else $error("history write pointer out of range");

  a_sweep_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |=> (fill_q != '0) && $stable(fill_q))
    else $error("history changed or empty during summing pass");
`endif

endmodule

>>> sv/trm_ctrl.sv
// Controller state machine sequencing one request through the datapath.
`timescale 1ns / 1ps

module trm_ctrl
  import trm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     avg_mode_i,
  input  trm_sts_t sts_i,
  output trm_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EVAL     = 4'd1;
  localparam logic [3:0] S_PROD     = 4'd2;
  localparam logic [3:0] S_DIV_RATE = 4'd3;
  localparam logic [3:0] S_WAIT_RATE = 4'd4;
  localparam logic [3:0] S_PUSH     = 4'd5;
  localparam logic [3:0] S_SUM      = 4'd6;
  localparam logic [3:0] S_DIV_MEAN = 4'd7;
  localparam logic [3:0] S_WAIT_MEAN = 4'd8;
  localparam logic [3:0] S_SCALE    = 4'd9;
  localparam logic [3:0] S_RAW      = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  logic [3:0] state_q, state_d;
  logic       upd_q, upd_d;

  always_comb begin
    state_d = state_q;
    upd_d   = upd_q;
    cmd_o   = '0;
    cmd_o.upd = upd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.span_neg && sts_i.win_hit) begin
          upd_d   = 1'b1;
          state_d = S_PROD;
        end else begin
          upd_d   = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = S_DIV_RATE;
      end
      S_DIV_RATE: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_RATE;
      end
      S_WAIT_RATE: begin
        if (sts_i.div_done) begin
          cmd_o.take_rate = 1'b1;
          state_d = avg_mode_i ? S_PUSH : S_RAW;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mean  = 1'b1;
        state_d = S_WAIT_MEAN;
      end
      S_WAIT_MEAN: begin
        if (sts_i.div_done) begin
          cmd_o.take_mean = 1'b1;
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = S_EMIT;
      end
      S_RAW: begin
        cmd_o.raw = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

>>> sv/throughput_rate_meter_core.sv
// Top level of the throughput rate meter: register file, controller and datapath.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] symbol_count, tdata[47:16] now_ms
// m_axis    out        tdata[31:0] speed, tuser[0] updated
// apb       in/out     0x0 bits_per_symbol, 0x4 window_ms, 0x8 averaging_mode
//
// A request that does not close a window goes from the span check straight to
// the output. A closing request in raw mode runs the product, the rate pass of
// the 42-step shared divider and the raw copy; in averaging mode it instead
// writes the rate into the history, adds the history summing pass (one entry
// per cycle through the memory read port) over all entries including the new
// rate, a second divider pass for the mean, and the scaling by bits per symbol.
// All control state clears asynchronously on rst_ni; the history starts empty.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled output only holds
// back the request whose result needs that register.

module throughput_rate_meter_core
  import trm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [47:0]         s_axis_tdata_i,   // [15:0] symbol_count, [47:16] now_ms
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,   // [31:0] speed
  output logic [0:0]          m_axis_tuser_o,   // [0] updated
  // Register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [BPS_W-1:0] bps_q;
  logic [WIN_W-1:0] window_q;
  logic             avg_q;

  trm_cmd_t cmd;
  trm_sts_t sts;
  logic     wr_en;
  logic     upd;

  // The register file is written on the access phase of a write; pready is
  // tied high so every transfer completes without wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= BPS_RESET;
      window_q <= WIN_RESET;
      avg_q    <= 1'b1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BITS_PER_SYM: bps_q    <= pwdata[BPS_W-1:0];
        REG_WINDOW_MS:    window_q <= pwdata[WIN_W-1:0];
        REG_AVG_MODE:     avg_q    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BITS_PER_SYM: prdata = DATA_W'(bps_q);
      REG_WINDOW_MS:    prdata = DATA_W'(window_q);
      REG_AVG_MODE:     prdata = DATA_W'(avg_q);
      default:          prdata = '0;
    endcase
  end

  // The controller walks each request through span check, rate division,
  // history update and averaging; the datapath holds all arithmetic and state.
  trm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .avg_mode_i (avg_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .bps_i       (bps_q),
    .window_i    (window_q),
    .count_i     (s_axis_tdata_i[15:0]),
    .now_i       (s_axis_tdata_i[47:16]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_speed_o (m_axis_tdata_o),
    .out_upd_o   (upd)
  );

  assign m_axis_tuser_o = upd;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request accepted while one is in flight");
`endif

endmodule
